### rtl/cljs_pkg.sv
// shared types, opcode constants and decode helpers for the load / relative jump step
// used by every module of the block; no dependencies
package cljs_pkg;

  localparam logic [15:0] PC_RESET = 16'h0100;
  localparam int          NUM_REGS = 7;
  localparam int          TDATA_IN_W = 24;
  localparam int          TDATA_OUT_W = 80;
  localparam int          QDEPTH = 2;
  localparam int          QPTR_W = $clog2(QDEPTH);
  localparam int          QCNT_W = $clog2(QDEPTH + 1);
  localparam int          CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FLAG  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRY_FLAG = 1'd1;

  // opcodes
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_JR       = 8'h18;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_JR_Z     = 8'h28;
  localparam logic [7:0] OP_JR_NC    = 8'h30;
  localparam logic [7:0] OP_JR_C     = 8'h38;
  localparam logic [7:0] OP_LD_FIRST = 8'h40;
  localparam logic [7:0] OP_LD_LAST  = 8'h7f;
  localparam logic [4:0] OP_LD_HL_ROW = 5'h0e;   // 0x70..0x77, stores to (hl) and halt

  // register codes inside an opcode
  localparam logic [2:0] CODE_HL_MEM = 3'd6;
  localparam logic [2:0] CODE_A      = 3'd7;

  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_A = 3'd6;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_BAD  = 3'd0;
  localparam kind_t KIND_NOP  = 3'd1;
  localparam kind_t KIND_JR   = 3'd2;
  localparam kind_t KIND_LD_R = 3'd3;
  localparam kind_t KIND_LD_M = 3'd4;

  typedef logic [2:0] cond_t;
  localparam cond_t COND_ALWAYS = 3'd0;
  localparam cond_t COND_NZ     = 3'd1;
  localparam cond_t COND_Z      = 3'd2;
  localparam cond_t COND_NC     = 3'd3;
  localparam cond_t COND_C      = 3'd4;

  localparam logic [3:0] CYC_NONE = 4'd0;
  localparam logic [3:0] CYC_4    = 4'd4;
  localparam logic [3:0] CYC_8    = 4'd8;
  localparam logic [3:0] CYC_12   = 4'd12;

  // classified instruction handed from front to back
  typedef struct packed {
    kind_t      kind;
    cond_t      cond;
    slot_t      dst;
    slot_t      src;
    logic [7:0] data;   // displacement for jr, memory byte for ld r,(hl)
  } uop_t;

  function automatic slot_t slot_of(input logic [2:0] code);
    slot_t s;
    s = (code == CODE_A) ? SLOT_A : code;
    return s;
  endfunction

endpackage

### rtl/cpu_load_and_relative_jump_step.sv
// top level of the load / relative jump step executor
// depends on cljs_pkg, cljs_front, cljs_fifo and cljs_back
//
// Executes one instruction per item: nop, jr e, jr nz/z/nc/c e, ld r,r' and ld r,(hl);
// any other opcode leaves state untouched and is reported as unsupported with a cycle
// count of zero. One item is taken every clock cycle in steady state while the result
// side accepts. An accepted item is classified and queued, then executed from the queue
// head once the result register is free; the result register then holds its result.
// A two-entry queue between the decoder and the execute stage absorbs a stall on the
// result side, so the input keeps flowing until the queue fills. The zero and carry
// flags are written via the configuration port while idle; that rule binds the user.
module cpu_load_and_relative_jump_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // opcode [7:0], next_byte [15:8], hl_memory_byte [23:16]
  input  logic [cljs_pkg::TDATA_IN_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // new_pc [15:0], cycle_count [19:16], reg_a [27:20], reg_b [35:28], reg_c [43:36],
  // reg_d [51:44], reg_e [59:52], reg_h [67:60], reg_l [75:68], zero [79:76]
  output logic [cljs_pkg::TDATA_OUT_W-1:0]     m_tdata,
  // unsupported [0]
  output logic                                 m_tuser,
  input  logic                                 cfg_we,
  input  logic [cljs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                 cfg_data
);

  logic           zero_flag;
  logic           carry_flag;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  cljs_pkg::uop_t push_uop;
  cljs_pkg::uop_t head_uop;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_flag  <= 1'b0;
      carry_flag <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cljs_pkg::CFG_ZERO_FLAG:  zero_flag  <= cfg_data;
        cljs_pkg::CFG_CARRY_FLAG: carry_flag <= cfg_data;
        default: ;
      endcase
    end
  end

  cljs_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_uop    (push_uop)
  );

  cljs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_uop (push_uop),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_uop (head_uop)
  );

  cljs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .zero_flag  (zero_flag),
    .carry_flag (carry_flag),
    .q_valid    (q_valid),
    .q_uop      (head_uop),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

### rtl/cljs_front.sv
// front end: accepts instruction items and classifies them into micro-ops
// depends on cljs_pkg; feeds cljs_fifo
module cljs_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cljs_pkg::TDATA_IN_W-1:0]  s_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output cljs_pkg::uop_t                   q_uop
);

  logic [7:0] opcode;
  logic [7:0] next_byte;
  logic [7:0] hl_memory_byte;

  assign opcode         = s_tdata[7:0];
  assign next_byte      = s_tdata[15:8];
  assign hl_memory_byte = s_tdata[23:16];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_uop      = '0;
    q_uop.kind = cljs_pkg::KIND_BAD;
    q_uop.cond = cljs_pkg::COND_ALWAYS;
    q_uop.dst  = cljs_pkg::slot_of(opcode[5:3]);
    q_uop.src  = cljs_pkg::slot_of(opcode[2:0]);
    q_uop.data = next_byte;
    unique case (opcode) inside
      cljs_pkg::OP_NOP: begin
        q_uop.kind = cljs_pkg::KIND_NOP;
      end
      cljs_pkg::OP_JR: begin
        q_uop.kind = cljs_pkg::KIND_JR;
      end
      cljs_pkg::OP_JR_NZ: begin
        q_uop.kind = cljs_pkg::KIND_JR;
        q_uop.cond = cljs_pkg::COND_NZ;
      end
      cljs_pkg::OP_JR_Z: begin
        q_uop.kind = cljs_pkg::KIND_JR;
        q_uop.cond = cljs_pkg::COND_Z;
      end
      cljs_pkg::OP_JR_NC: begin
        q_uop.kind = cljs_pkg::KIND_JR;
        q_uop.cond = cljs_pkg::COND_NC;
      end
      cljs_pkg::OP_JR_C: begin
        q_uop.kind = cljs_pkg::KIND_JR;
        q_uop.cond = cljs_pkg::COND_C;
      end
      [cljs_pkg::OP_LD_FIRST:cljs_pkg::OP_LD_LAST]: begin
        if (opcode[7:3] == cljs_pkg::OP_LD_HL_ROW) begin
          q_uop.kind = cljs_pkg::KIND_BAD;
        end else if (opcode[2:0] == cljs_pkg::CODE_HL_MEM) begin
          q_uop.kind = cljs_pkg::KIND_LD_M;
          q_uop.data = hl_memory_byte;
        end else begin
          q_uop.kind = cljs_pkg::KIND_LD_R;
        end
      end
      default: begin
        q_uop.kind = cljs_pkg::KIND_BAD;
      end
    endcase
  end

endmodule

### rtl/cljs_fifo.sv
// short micro-op queue between front and back
// depends on cljs_pkg for the queue depth and the micro-op type
module cljs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cljs_pkg::uop_t push_uop,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output cljs_pkg::uop_t head_uop
);

  cljs_pkg::uop_t                 slots [cljs_pkg::QDEPTH];
  logic [cljs_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cljs_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cljs_pkg::QCNT_W-1:0]    count;

  assign full     = (count == cljs_pkg::QCNT_W'(cljs_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign head_uop = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cljs_pkg::QPTR_W'(cljs_pkg::QDEPTH - 1)) ? '0 :
                  wr_ptr + cljs_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cljs_pkg::QPTR_W'(cljs_pkg::QDEPTH - 1)) ? '0 :
                  rd_ptr + cljs_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + cljs_pkg::QCNT_W'(1);
        2'b01:   count <= count - cljs_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/cljs_back.sv
// back end: executes micro-ops against the register file and program counter
// depends on cljs_pkg; drains cljs_fifo and drives the result register
module cljs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              zero_flag,
  input  logic                              carry_flag,
  input  logic                              q_valid,
  input  cljs_pkg::uop_t                    q_uop,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cljs_pkg::TDATA_OUT_W-1:0]  m_tdata,
  output logic                              m_tuser
);

  logic [7:0]  regs [cljs_pkg::NUM_REGS];
  logic [7:0]  regs_next [cljs_pkg::NUM_REGS];
  logic [15:0] pc;
  logic [15:0] pc_next;
  logic [3:0]  cycles_next;
  logic        bad_next;
  logic        taken;
  logic        exec;

  logic [7:0]  out_regs [cljs_pkg::NUM_REGS];
  logic [15:0] out_pc;
  logic [3:0]  out_cycles;
  logic        out_bad;

  // result register frees up when empty or being taken this cycle
  assign exec  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = exec;

  always_comb begin
    unique case (q_uop.cond)
      cljs_pkg::COND_NZ: taken = !zero_flag;
      cljs_pkg::COND_Z:  taken = zero_flag;
      cljs_pkg::COND_NC: taken = !carry_flag;
      cljs_pkg::COND_C:  taken = carry_flag;
      default:           taken = 1'b1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < cljs_pkg::NUM_REGS; i++) begin
      regs_next[i] = regs[i];
    end
    pc_next     = pc;
    cycles_next = cljs_pkg::CYC_NONE;
    bad_next    = 1'b0;
    unique case (q_uop.kind)
      cljs_pkg::KIND_NOP: begin
        pc_next     = pc + 16'd1;
        cycles_next = cljs_pkg::CYC_4;
      end
      cljs_pkg::KIND_JR: begin
        if (taken) begin
          // sign-extended displacement, wraps modulo 2^16
          pc_next     = pc + 16'd2 + {{8{q_uop.data[7]}}, q_uop.data};
          cycles_next = cljs_pkg::CYC_12;
        end else begin
          pc_next     = pc + 16'd2;
          cycles_next = cljs_pkg::CYC_8;
        end
      end
      cljs_pkg::KIND_LD_R: begin
        regs_next[q_uop.dst] = regs[q_uop.src];
        pc_next              = pc + 16'd1;
        cycles_next          = cljs_pkg::CYC_4;
      end
      cljs_pkg::KIND_LD_M: begin
        regs_next[q_uop.dst] = q_uop.data;
        pc_next              = pc + 16'd1;
        cycles_next          = cljs_pkg::CYC_8;
      end
      default: begin
        bad_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= cljs_pkg::PC_RESET;
      m_tvalid <= 1'b0;
      for (int i = 0; i < cljs_pkg::NUM_REGS; i++) begin
        regs[i] <= 8'd0;
      end
    end else begin
      if (exec) begin
        pc <= pc_next;
        for (int i = 0; i < cljs_pkg::NUM_REGS; i++) begin
          regs[i] <= regs_next[i];
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_pc     <= pc_next;
      out_cycles <= cycles_next;
      out_bad    <= bad_next;
      for (int i = 0; i < cljs_pkg::NUM_REGS; i++) begin
        out_regs[i] <= regs_next[i];
      end
    end
  end

  assign m_tdata = {4'd0, out_regs[5], out_regs[4], out_regs[3], out_regs[2], out_regs[1],
                    out_regs[0], out_regs[cljs_pkg::SLOT_A], out_cycles, out_pc};
  assign m_tuser = out_bad;

  a_pc_reset: assert property (@(posedge clk) rst |=> pc == cljs_pkg::PC_RESET)
    else $error("pc not at reset value after reset");

  a_bad_no_cycles: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_bad == (out_cycles == cljs_pkg::CYC_NONE)))
    else $error("unsupported flag and cycle count disagree");

  a_bad_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (exec && q_uop.kind == cljs_pkg::KIND_BAD) |=> pc == $past(pc))
    else $error("unsupported opcode moved the pc");

  a_result_pc: assert property (@(posedge clk) disable iff (rst)
    $past(exec) |-> out_pc == pc)
    else $error("reported pc differs from architectural pc");

endmodule

### bench/cljs_step_checker.sv
// result checker for the load / relative jump step executor
// watches the input, result and configuration ports, predicts every result; uses cljs_pkg
module cljs_step_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [cljs_pkg::TDATA_IN_W-1:0]  s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [cljs_pkg::TDATA_OUT_W-1:0] m_tdata,
  input  logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [cljs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                             cfg_data,
  output int                               fail_count,
  output int                               outstanding
);

  typedef struct packed {
    logic [15:0]     pc;
    logic [3:0]      cycles;
    logic            unsupported;
    logic [7:0][7:0] regs;   // indexed by register code, code 6 unused
  } step_result_t;

  step_result_t    pending_results[$];
  logic [7:0][7:0] gpr;
  logic [15:0]     pc_now;
  logic            zero_now;
  logic            carry_now;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic execute_instruction(input logic [7:0] op, input logic [7:0] disp,
                                     input logic [7:0] mem_byte);
    step_result_t r;
    logic         taken;
    r = '0;
    r.cycles = cljs_pkg::CYC_NONE;
    if (op == cljs_pkg::OP_NOP) begin
      pc_now   = pc_now + 16'd1;
      r.cycles = cljs_pkg::CYC_4;
    end else if (op == cljs_pkg::OP_JR || op == cljs_pkg::OP_JR_NZ ||
                 op == cljs_pkg::OP_JR_Z || op == cljs_pkg::OP_JR_NC ||
                 op == cljs_pkg::OP_JR_C) begin
      case (op)
        cljs_pkg::OP_JR_NZ: taken = !zero_now;
        cljs_pkg::OP_JR_Z:  taken = zero_now;
        cljs_pkg::OP_JR_NC: taken = !carry_now;
        cljs_pkg::OP_JR_C:  taken = carry_now;
        default:            taken = 1'b1;
      endcase
      if (taken) begin
        // signed displacement, target wraps at 64k
        pc_now   = pc_now + 16'd2 + {{8{disp[7]}}, disp};
        r.cycles = cljs_pkg::CYC_12;
      end else begin
        pc_now   = pc_now + 16'd2;
        r.cycles = cljs_pkg::CYC_8;
      end
    end else if (op >= cljs_pkg::OP_LD_FIRST && op <= cljs_pkg::OP_LD_LAST &&
                 op[7:3] != cljs_pkg::OP_LD_HL_ROW) begin
      if (op[2:0] == cljs_pkg::CODE_HL_MEM) begin
        gpr[op[5:3]] = mem_byte;
        r.cycles     = cljs_pkg::CYC_8;
      end else begin
        gpr[op[5:3]] = gpr[op[2:0]];
        r.cycles     = cljs_pkg::CYC_4;
      end
      pc_now = pc_now + 16'd1;
    end else begin
      // anything else leaves pc and registers alone
      r.unsupported = 1'b1;
    end
    r.pc   = pc_now;
    r.regs = gpr;
    pending_results.push_back(r);
  endtask

  task automatic check_result();
    step_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result item with nothing expected, pc %0h", m_tdata[15:0]));
    end else begin
      want = pending_results.pop_front();
      compare_field("new_pc", m_tdata[15:0], want.pc);
      compare_field("cycle_count", 16'(m_tdata[19:16]), 16'(want.cycles));
      compare_field("unsupported", 16'(m_tuser), 16'(want.unsupported));
      compare_field("reg_a", 16'(m_tdata[27:20]), 16'(want.regs[cljs_pkg::CODE_A]));
      // b, c, d, e, h, l follow a in code order, all codes below the memory operand
      for (int k = 0; k < cljs_pkg::CODE_HL_MEM; k++)
        compare_field($sformatf("register code %0d", k), 16'(m_tdata[28 + 8*k +: 8]),
                      16'(want.regs[k]));
      compare_field("padding", 16'(m_tdata[79:76]), 16'h0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gpr       = '0;
      pc_now    = cljs_pkg::PC_RESET;
      zero_now  = 1'b0;
      carry_now = 1'b0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_result();
      if (cfg_we) begin
        case (cfg_index)
          cljs_pkg::CFG_ZERO_FLAG:  zero_now  = cfg_data;
          cljs_pkg::CFG_CARRY_FLAG: carry_now = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        execute_instruction(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
    end
    outstanding <= pending_results.size();
  end

endmodule

### bench/cpu_load_and_relative_jump_step_tb.sv
// testbench top for the load / relative jump step executor
// drives instructions and flag writes, with cljs_step_checker alongside; uses cljs_pkg
module cpu_load_and_relative_jump_step_tb;

  localparam int RANDOM_ITEMS = 600;

  localparam logic [2:0] CODE_B = 3'd0;
  localparam logic [2:0] CODE_D = 3'd2;
  localparam logic [2:0] CODE_E = 3'd3;
  localparam logic [2:0] CODE_H = 3'd4;
  localparam logic [2:0] CODE_L = 3'd5;

  localparam logic [7:0] OP_LD_HL_B   = 8'h70;
  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] OP_CB_PREFIX = 8'hcb;
  localparam logic [7:0] OP_RST_38    = 8'hff;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cljs_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [cljs_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic                             m_tuser;
  logic                             cfg_we = 1'b0;
  logic [cljs_pkg::CFG_IDX_W-1:0]   cfg_index = cljs_pkg::CFG_ZERO_FLAG;
  logic                             cfg_data = 1'b0;
  int                               fail_count;
  int                               outstanding;
  int                               send_idle_pct = 0;
  int                               recv_idle_pct = 0;

  cpu_load_and_relative_jump_step u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cljs_step_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] ld_op(input logic [2:0] dst, input logic [2:0] src);
    return cljs_pkg::OP_LD_FIRST | {2'b00, dst, src};
  endfunction

  function automatic logic [2:0] random_reg_code();
    logic [2:0] c;
    c = 3'($urandom_range(6));
    return (c == cljs_pkg::CODE_HL_MEM) ? cljs_pkg::CODE_A : c;
  endfunction

  task automatic send_item(input logic [7:0] op, input logic [7:0] next_byte,
                           input logic [7:0] hl_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hl_byte, next_byte, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off the sender until every expected item has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_flags(input logic zero_val, input logic carry_val);
    cfg_we    <= 1'b1;
    cfg_index <= cljs_pkg::CFG_ZERO_FLAG;
    cfg_data  <= zero_val;
    @(posedge clk);
    cfg_index <= cljs_pkg::CFG_CARRY_FLAG;
    cfg_data  <= carry_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    logic [7:0] op;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      op = cljs_pkg::OP_NOP;
    end else if (pick < 30) begin
      case ($urandom_range(4))
        0:       op = cljs_pkg::OP_JR;
        1:       op = cljs_pkg::OP_JR_NZ;
        2:       op = cljs_pkg::OP_JR_Z;
        3:       op = cljs_pkg::OP_JR_NC;
        default: op = cljs_pkg::OP_JR_C;
      endcase
    end else if (pick < 55) begin
      op = ld_op(random_reg_code(), cljs_pkg::CODE_HL_MEM);
    end else if (pick < 85) begin
      op = ld_op(random_reg_code(), random_reg_code());
    end else if (pick < 88) begin
      op = OP_CB_PREFIX;
    end else begin
      op = 8'($urandom_range(255));
    end
    send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  initial begin
    int sent;
    int phase_len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: flags at their reset value of zero
    send_item(cljs_pkg::OP_NOP, 8'hff, 8'hff);
    send_item(ld_op(cljs_pkg::CODE_A, cljs_pkg::CODE_HL_MEM), 8'h00, 8'hff);
    send_item(ld_op(CODE_B, cljs_pkg::CODE_HL_MEM), 8'hff, 8'h80);
    send_item(ld_op(CODE_L, cljs_pkg::CODE_HL_MEM), 8'h00, 8'h5a);
    send_item(ld_op(CODE_E, cljs_pkg::CODE_HL_MEM), 8'h00, 8'h00);
    send_item(ld_op(CODE_D, cljs_pkg::CODE_A), 8'h00, 8'h00);
    send_item(ld_op(cljs_pkg::CODE_A, CODE_L), 8'h00, 8'h00);
    send_item(ld_op(cljs_pkg::CODE_A, cljs_pkg::CODE_A), 8'h00, 8'h00);
    send_item(ld_op(CODE_H, CODE_B), 8'h00, 8'h00);
    send_item(OP_CB_PREFIX, 8'h12, 8'h34);
    send_item(OP_HALT, 8'hff, 8'hff);
    send_item(OP_LD_HL_B, 8'h80, 8'h01);
    send_item(OP_RST_38, 8'h7f, 8'hfe);
    // three full backward jumps take pc below zero, then forward past the top
    send_item(cljs_pkg::OP_JR, 8'h80, 8'h00);
    send_item(cljs_pkg::OP_JR, 8'h80, 8'h00);
    send_item(cljs_pkg::OP_JR, 8'h80, 8'h00);
    send_item(cljs_pkg::OP_JR, 8'h7f, 8'h00);
    send_item(cljs_pkg::OP_JR, 8'hff, 8'h00);
    send_item(cljs_pkg::OP_JR_NZ, 8'h10, 8'h00);
    send_item(cljs_pkg::OP_JR_Z, 8'h10, 8'h00);
    send_item(cljs_pkg::OP_JR_NC, 8'hf0, 8'h00);
    send_item(cljs_pkg::OP_JR_C, 8'hf0, 8'h00);
    drain();
    set_flags(1'b1, 1'b1);
    send_item(cljs_pkg::OP_JR_NZ, 8'h22, 8'h00);
    send_item(cljs_pkg::OP_JR_Z, 8'h22, 8'h00);
    send_item(cljs_pkg::OP_JR_NC, 8'hfe, 8'h00);
    send_item(cljs_pkg::OP_JR_C, 8'hfe, 8'h00);

    // random phases, flags rewritten while idle before each
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 49;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      set_flags(1'($urandom_range(1)), 1'($urandom_range(1)));
      phase_len = $urandom_range(30, 80);
      repeat (phase_len) begin
        random_item();
        sent++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
rtl/cljs_pkg.sv
rtl/cljs_front.sv
rtl/cljs_fifo.sv
rtl/cljs_back.sv
rtl/cpu_load_and_relative_jump_step.sv
bench/cljs_step_checker.sv
bench/cpu_load_and_relative_jump_step_tb.sv
